[rtl/mrpsm_pkg.sv]
// package: shared constants and types for the partial-sum merge router
package mrpsm_pkg;
	localparam int TABLE_DEPTH_DEF = 16;
	localparam int KEY_WIDTH_DEF = 16;
	localparam int DATA_WIDTH_DEF = 32;
	localparam int COORD_W = 8;
	localparam int NIB_W = 4;
	localparam int GS_W = 4;
	localparam int ROUTE_W = 3;
	localparam logic [GS_W-1:0] GS_RESET = 4'd8;
	localparam logic [ROUTE_W-1:0] ROUTE_UP = 3'd0;
	localparam logic [ROUTE_W-1:0] ROUTE_DOWN = 3'd1;
	localparam logic [ROUTE_W-1:0] ROUTE_LEFT = 3'd2;
	localparam logic [ROUTE_W-1:0] ROUTE_RIGHT = 3'd3;
	localparam logic [ROUTE_W-1:0] ROUTE_ABSORBED = 3'd4;
	localparam logic [ROUTE_W-1:0] ROUTE_COMPLETE = 3'd5;
	localparam logic [ROUTE_W-1:0] ROUTE_DROPPED = 3'd6;
	localparam logic REG_NODE_COORD = 1'b0;
	localparam logic REG_GROUP_SIZE = 1'b1;
	localparam int CFG_W = 8;

	// per-cell command: one packet looked up against the row
	typedef struct packed {
		logic       lookup;
		logic       sel;
		logic       alloc;
		logic       release_e;
		logic       update;
	} mrpsm_cmd_t;
endpackage

[rtl/mrpsm_cell.sv]
// one table entry: key, sums, count, valid; compares and holds its part of the state
module mrpsm_cell #(
	parameter int KEY_WIDTH = mrpsm_pkg::KEY_WIDTH_DEF,
	parameter int DATA_WIDTH = mrpsm_pkg::DATA_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [3*KEY_WIDTH-1:0]  key,
	input  logic [DATA_WIDTH-1:0]   v0,
	input  logic [DATA_WIDTH-1:0]   v1,
	input  logic [mrpsm_pkg::GS_W-1:0] cnt_in,
	input  logic [DATA_WIDTH-1:0]   s0_in,
	input  logic [DATA_WIDTH-1:0]   s1_in,
	input  mrpsm_pkg::mrpsm_cmd_t   cmd,
	input  logic                    hit_in,
	input  logic                    free_in,
	output logic                    hit_out,
	output logic                    free_out,
	output logic                    hit_here,
	output logic                    free_here,
	output logic [DATA_WIDTH-1:0]   sum0,
	output logic [DATA_WIDTH-1:0]   sum1,
	output logic [mrpsm_pkg::GS_W-1:0] count
);
	import mrpsm_pkg::*;
	logic                  valid_q;
	logic [3*KEY_WIDTH-1:0] key_q;
	logic [DATA_WIDTH-1:0] sum0_q, sum1_q;
	logic [GS_W-1:0]       count_q;
	logic                  match;

	assign match     = valid_q && (key_q == key);
	assign hit_here  = match && !hit_in;
	assign hit_out   = hit_in || match;
	assign free_here = !valid_q && !free_in;
	assign free_out  = free_in || !valid_q;
	assign sum0      = sum0_q;
	assign sum1      = sum1_q;
	assign count     = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.lookup && cmd.sel) begin
			if (cmd.release_e) begin
				valid_q <= 1'b0;
			end else if (cmd.alloc) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.lookup && cmd.sel) begin
			if (cmd.alloc) begin
				key_q   <= key;
				sum0_q  <= v0;
				sum1_q  <= v1;
				count_q <= GS_W'(1);
			end else if (cmd.update) begin
				sum0_q  <= s0_in;
				sum1_q  <= s1_in;
				count_q <= cnt_in;
			end
		end
	end
endmodule

[rtl/mesh_router_partial_sum_merge_core.sv]
// top level: xy routing and tag-matched accumulation over a row of entry cells
// One packet is taken per cycle whenever start is high and busy low; busy stays low, so
// the block accepts an item every clock. Each item yields one result with strobe high in
// the following cycle; the lookup runs combinationally across the row of TABLE_DEPTH
// cells; the updated entry is written back at the same edge. Results cannot be stalled.
module mesh_router_partial_sum_merge_core #(
	parameter int TABLE_DEPTH = mrpsm_pkg::TABLE_DEPTH_DEF,
	parameter int KEY_WIDTH = mrpsm_pkg::KEY_WIDTH_DEF,
	parameter int DATA_WIDTH = mrpsm_pkg::DATA_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [mrpsm_pkg::COORD_W-1:0]  dest_coord,
	input  logic [KEY_WIDTH-1:0]           key_r,
	input  logic [KEY_WIDTH-1:0]           key_b,
	input  logic [KEY_WIDTH-1:0]           key_p,
	input  logic signed [DATA_WIDTH-1:0]   val0,
	input  logic signed [DATA_WIDTH-1:0]   val1,
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [mrpsm_pkg::CFG_W-1:0]    cfg_data,
	output logic                           strobe,
	output logic [mrpsm_pkg::ROUTE_W-1:0]  route,
	output logic [mrpsm_pkg::COORD_W-1:0]  out_dest,
	output logic [KEY_WIDTH-1:0]           out_key_r,
	output logic [KEY_WIDTH-1:0]           out_key_b,
	output logic [KEY_WIDTH-1:0]           out_key_p,
	output logic signed [DATA_WIDTH-1:0]   out_val0,
	output logic signed [DATA_WIDTH-1:0]   out_val1
);
	import mrpsm_pkg::*;

	logic [COORD_W-1:0] node_q;
	logic [GS_W-1:0]    gs_q;
	logic               acc;
	logic               here;
	logic [3*KEY_WIDTH-1:0] key;
	logic [TABLE_DEPTH:0] hit_c, free_c;
	logic [TABLE_DEPTH-1:0] hit_v, free_v;
	logic [DATA_WIDTH-1:0] s0_v [TABLE_DEPTH];
	logic [DATA_WIDTH-1:0] s1_v [TABLE_DEPTH];
	logic [GS_W-1:0]       c_v  [TABLE_DEPTH];
	logic [DATA_WIDTH-1:0] hs0, hs1, ns0, ns1;
	logic [GS_W-1:0]       hc, nc;
	logic                  any_hit, any_free, done_hit;
	logic [ROUTE_W-1:0]    rt;
	logic [COORD_W-1:0]    od;
	logic [DATA_WIDTH-1:0] ov0, ov1;
	logic                  strobe_q;
	logic [ROUTE_W-1:0]    route_q;
	logic [COORD_W-1:0]    dest_q;
	logic [3*KEY_WIDTH-1:0] key_q;
	logic [DATA_WIDTH-1:0] v0_q, v1_q;

	assign busy = 1'b0;
	assign acc  = start && !busy;
	assign key  = {key_r, key_b, key_p};
	assign here = (dest_coord == node_q);
	assign hit_c[0]  = 1'b0;
	assign free_c[0] = 1'b0;

	genvar g;
	for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		mrpsm_cmd_t cmd;
		assign cmd.lookup    = acc && here;
		assign cmd.sel       = hit_v[g] || (!any_hit && free_v[g]);
		assign cmd.alloc     = !hit_v[g] && (gs_q > GS_W'(1));
		assign cmd.release_e = hit_v[g] && done_hit;
		assign cmd.update    = hit_v[g] && !done_hit;
		mrpsm_cell #(.KEY_WIDTH(KEY_WIDTH), .DATA_WIDTH(DATA_WIDTH)) u_cell (
			.clk(clk), .arst_n(arst_n), .key(key), .v0(val0), .v1(val1),
			.cnt_in(nc), .s0_in(ns0), .s1_in(ns1), .cmd(cmd),
			.hit_in(hit_c[g]), .free_in(free_c[g]),
			.hit_out(hit_c[g+1]), .free_out(free_c[g+1]),
			.hit_here(hit_v[g]), .free_here(free_v[g]),
			.sum0(s0_v[g]), .sum1(s1_v[g]), .count(c_v[g])
		);
	end

	always_comb begin
		hs0 = '0;
		hs1 = '0;
		hc  = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			hs0 = hs0 | (s0_v[i] & {DATA_WIDTH{hit_v[i]}});
			hs1 = hs1 | (s1_v[i] & {DATA_WIDTH{hit_v[i]}});
			hc  = hc  | (c_v[i]  & {GS_W{hit_v[i]}});
		end
	end

	assign any_hit  = hit_c[TABLE_DEPTH];
	assign any_free = free_c[TABLE_DEPTH];
	assign ns0 = hs0 + val0;
	assign ns1 = hs1 + val1;
	assign nc  = hc + GS_W'(1);
	assign done_hit = (nc >= gs_q);

	always_comb begin
		od  = '0;
		ov0 = '0;
		ov1 = '0;
		if (dest_coord[7:4] < node_q[7:4]) begin
			rt = ROUTE_UP;
		end else if (dest_coord[7:4] > node_q[7:4]) begin
			rt = ROUTE_DOWN;
		end else if (dest_coord[3:0] < node_q[3:0]) begin
			rt = ROUTE_LEFT;
		end else if (dest_coord[3:0] > node_q[3:0]) begin
			rt = ROUTE_RIGHT;
		end else if (any_hit) begin
			rt = done_hit ? ROUTE_COMPLETE : ROUTE_ABSORBED;
			if (done_hit) begin
				ov0 = ns0;
				ov1 = ns1;
			end
		end else if (gs_q <= GS_W'(1)) begin
			rt  = ROUTE_COMPLETE;
			ov0 = val0;
			ov1 = val1;
		end else if (!any_free) begin
			rt = ROUTE_DROPPED;
		end else begin
			rt = ROUTE_ABSORBED;
		end
		if (!here) begin
			od  = dest_coord;
			ov0 = val0;
			ov1 = val1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_q   <= '0;
			gs_q     <= GS_RESET;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= acc;
			if (cfg_we) begin
				case (cfg_index)
					REG_NODE_COORD: node_q <= cfg_data;
					REG_GROUP_SIZE: gs_q   <= cfg_data[GS_W-1:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			route_q <= rt;
			dest_q  <= od;
			key_q   <= key;
			v0_q    <= ov0;
			v1_q    <= ov1;
		end
	end

	assign strobe    = strobe_q;
	assign route     = route_q;
	assign out_dest  = dest_q;
	assign out_key_r = key_q[3*KEY_WIDTH-1:2*KEY_WIDTH];
	assign out_key_b = key_q[2*KEY_WIDTH-1:KEY_WIDTH];
	assign out_key_p = key_q[KEY_WIDTH-1:0];
	assign out_val0  = v0_q;
	assign out_val1  = v1_q;
endmodule

[test/tb_top.sv]
// testbench: routing and partial-sum merge checks for the mesh router node
`timescale 1ns / 100ps

class merge_scoreboard;
	logic [7:0] node_coord;
	logic [3:0] group_size;
	bit entry_valid[16];
	logic [47:0] entry_key[16];
	logic [31:0] entry_sum0[16];
	logic [31:0] entry_sum1[16];
	logic [3:0] entry_count[16];
	logic [2:0] exp_route[$];
	logic [7:0] exp_dest[$];
	logic [47:0] exp_key[$];
	logic [31:0] exp_v0[$];
	logic [31:0] exp_v1[$];
	int mismatches;
	int results_seen;
	int route_hist[7];

	function new();
		node_coord = 8'h00;
		group_size = mrpsm_pkg::GS_RESET;
		for (int i = 0; i < 16; i++) entry_valid[i] = 0;
		mismatches = 0;
		results_seen = 0;
		for (int i = 0; i < 7; i++) route_hist[i] = 0;
	endfunction

	function int pending();
		return exp_route.size();
	endfunction

	function int live_entries();
		int n;
		n = 0;
		for (int i = 0; i < 16; i++) if (entry_valid[i]) n++;
		return n;
	endfunction

	function void push(logic [2:0] r, logic [7:0] d, logic [47:0] k, logic [31:0] a,
			logic [31:0] b);
		exp_route.insert(exp_route.size(), r);
		exp_dest.insert(exp_dest.size(), d);
		exp_key.insert(exp_key.size(), k);
		exp_v0.insert(exp_v0.size(), a);
		exp_v1.insert(exp_v1.size(), b);
	endfunction

	function void note_item(logic [7:0] dest, logic [47:0] key, logic [31:0] a,
			logic [31:0] b);
		int hit;
		int free_idx;
		logic [31:0] s0;
		logic [31:0] s1;
		logic [3:0] cnt;
		hit = -1;
		free_idx = -1;
		if (dest[7:4] < node_coord[7:4]) begin
			push(mrpsm_pkg::ROUTE_UP, dest, key, a, b);
			return;
		end
		if (dest[7:4] > node_coord[7:4]) begin
			push(mrpsm_pkg::ROUTE_DOWN, dest, key, a, b);
			return;
		end
		if (dest[3:0] < node_coord[3:0]) begin
			push(mrpsm_pkg::ROUTE_LEFT, dest, key, a, b);
			return;
		end
		if (dest[3:0] > node_coord[3:0]) begin
			push(mrpsm_pkg::ROUTE_RIGHT, dest, key, a, b);
			return;
		end
		for (int i = 0; i < 16; i++) begin
			if (entry_valid[i]) begin
				if (hit < 0 && entry_key[i] == key) hit = i;
			end else if (free_idx < 0) begin
				free_idx = i;
			end
		end
		if (hit >= 0) begin
			s0 = entry_sum0[hit] + a;
			s1 = entry_sum1[hit] + b;
			cnt = entry_count[hit] + 4'd1;
			if (cnt >= group_size) begin
				entry_valid[hit] = 0;
				push(mrpsm_pkg::ROUTE_COMPLETE, 8'h00, key, s0, s1);
			end else begin
				entry_sum0[hit] = s0;
				entry_sum1[hit] = s1;
				entry_count[hit] = cnt;
				push(mrpsm_pkg::ROUTE_ABSORBED, 8'h00, key, 32'h0, 32'h0);
			end
			return;
		end
		if (group_size <= 4'd1) begin
			push(mrpsm_pkg::ROUTE_COMPLETE, 8'h00, key, a, b);
			return;
		end
		if (free_idx < 0) begin
			push(mrpsm_pkg::ROUTE_DROPPED, 8'h00, key, 32'h0, 32'h0);
			return;
		end
		entry_valid[free_idx] = 1;
		entry_key[free_idx] = key;
		entry_sum0[free_idx] = a;
		entry_sum1[free_idx] = b;
		entry_count[free_idx] = 4'd1;
		push(mrpsm_pkg::ROUTE_ABSORBED, 8'h00, key, 32'h0, 32'h0);
	endfunction

	function void check_result(logic [2:0] r, logic [7:0] d, logic [47:0] k, logic [31:0] a,
			logic [31:0] b);
		logic [2:0] er;
		logic [7:0] ed;
		logic [47:0] ek;
		logic [31:0] ea;
		logic [31:0] eb;
		results_seen++;
		if (exp_route.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) $display("unexpected result route=%0d", r);
			return;
		end
		er = exp_route.pop_front();
		ed = exp_dest.pop_front();
		ek = exp_key.pop_front();
		ea = exp_v0.pop_front();
		eb = exp_v1.pop_front();
		if (er < 7) route_hist[er]++;
		if (r !== er || d !== ed || k !== ek || a !== ea || b !== eb) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: exp r=%0d d=%h k=%h v=%h/%h got r=%0d d=%h k=%h v=%h/%h",
					er, ed, ek, ea, eb, r, d, k, a, b);
		end
	endfunction
endclass

module tb_top;
	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [7:0] dest_coord;
	logic [15:0] key_r;
	logic [15:0] key_b;
	logic [15:0] key_p;
	logic signed [31:0] val0;
	logic signed [31:0] val1;
	logic cfg_we;
	logic cfg_index;
	logic [7:0] cfg_data;
	logic strobe;
	logic [2:0] route;
	logic [7:0] out_dest;
	logic [15:0] out_key_r;
	logic [15:0] out_key_b;
	logic [15:0] out_key_p;
	logic signed [31:0] out_val0;
	logic signed [31:0] out_val1;

	merge_scoreboard sums;
	int items_sent;
	bit gaps_on;
	logic [47:0] key_pool[8];

	mesh_router_partial_sum_merge_core i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.dest_coord(dest_coord), .key_r(key_r), .key_b(key_b), .key_p(key_p),
		.val0(val0), .val1(val1), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .strobe(strobe), .route(route), .out_dest(out_dest),
		.out_key_r(out_key_r), .out_key_b(out_key_b), .out_key_p(out_key_p),
		.out_val0(out_val0), .out_val1(out_val1)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	always @(posedge clk) begin
		if (arst_n && strobe)
			sums.check_result(route, out_dest, {out_key_r, out_key_b, out_key_p},
				out_val0, out_val1);
	end

	task automatic send_item(logic [7:0] d, logic [47:0] k, logic [31:0] a, logic [31:0] b);
		int gap;
		gap = gaps_on ? $urandom_range(0, 17) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		dest_coord <= d;
		{key_r, key_b, key_p} <= k;
		val0 <= a;
		val1 <= b;
		@(posedge clk);
		while (busy) @(posedge clk);
		sums.note_item(d, k, a, b);
		items_sent++;
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sums.pending() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [7:0] data);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == mrpsm_pkg::REG_NODE_COORD) sums.node_coord = data;
		else sums.group_size = data[3:0];
	endtask

	task automatic random_phase(int n);
		logic [47:0] k;
		logic [7:0] d;
		int sel;
		for (int i = 0; i < n; i++) begin
			gaps_on = ((i / 40) % 3) != 2;
			sel = $urandom_range(0, 99);
			k = key_pool[$urandom_range(0, 7)];
			if (sel < 65) d = sums.node_coord;
			else if (sel < 70) begin
				d = sums.node_coord;
				k = 48'({$urandom, $urandom});
			end else d = 8'($urandom);
			send_item(d, k, $urandom, $urandom);
		end
	endtask

	initial begin
		#2000000;
		$display("timeout");
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		sums = new();
		items_sent = 0;
		gaps_on = 1;
		arst_n = 1'b0;
		start = 1'b0;
		dest_coord = '0;
		key_r = '0;
		key_b = '0;
		key_p = '0;
		val0 = '0;
		val1 = '0;
		cfg_we = 1'b0;
		cfg_index = 1'b0;
		cfg_data = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: all routes from a mid node, wrap of sums, full table
		write_reg(mrpsm_pkg::REG_NODE_COORD, 8'h77);
		write_reg(mrpsm_pkg::REG_GROUP_SIZE, 8'd2);
		send_item(8'h00, 48'h0, 32'h0, 32'h0);
		send_item(8'hff, 48'hffff_ffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
		send_item(8'h70, 48'h1, 32'h1, 32'h2);
		send_item(8'h7f, 48'h2, 32'h3, 32'h4);
		send_item(8'h77, 48'h5, 32'h7fff_ffff, 32'h8000_0000);
		send_item(8'h77, 48'h5, 32'h7fff_ffff, 32'h8000_0000);
		for (int i = 0; i < 17; i++)
			send_item(8'h77, 48'h100 + i, i, -i);
		drain();
		// empty the table and restart with other settings
		for (int i = 0; i < 16; i++) send_item(8'h77, 48'h100 + i, 1, 1);

		for (int i = 0; i < 8; i++) key_pool[i] = 48'({$urandom, $urandom});
		write_reg(mrpsm_pkg::REG_NODE_COORD, 8'h00);
		write_reg(mrpsm_pkg::REG_GROUP_SIZE, 8'd15);
		random_phase(200);
		write_reg(mrpsm_pkg::REG_NODE_COORD, 8'hff);
		write_reg(mrpsm_pkg::REG_GROUP_SIZE, 8'd2);
		random_phase(200);
		write_reg(mrpsm_pkg::REG_NODE_COORD, 8'($urandom));
		write_reg(mrpsm_pkg::REG_GROUP_SIZE, 8'($urandom_range(3, 8)));
		random_phase(200);
		write_reg(mrpsm_pkg::REG_NODE_COORD, 8'($urandom));
		write_reg(mrpsm_pkg::REG_GROUP_SIZE, 8'($urandom_range(2, 15)));
		random_phase(200);

		drain();
		repeat (10) @(posedge clk);
		$display("sent %0d items, %0d results; up %0d down %0d left %0d right %0d",
			items_sent, sums.results_seen, sums.route_hist[0], sums.route_hist[1],
			sums.route_hist[2], sums.route_hist[3]);
		$display("absorbed %0d complete %0d dropped %0d, %0d mismatches",
			sums.route_hist[4], sums.route_hist[5], sums.route_hist[6], sums.mismatches);
		if (sums.mismatches == 0 && sums.pending() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule
